[rtl/rpsc_pkg.sv]
// ----------------------------------------------------------------------------
// rpsc_pkg
// Shared types and constants of the rotary peak scan controller.
// ----------------------------------------------------------------------------
package rpsc_pkg;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_INDEX = 2'd1;
  localparam logic [1:0] CMD_EDGE  = 2'd2;

  localparam logic [2:0] MODE_STARTUP  = 3'd0;
  localparam logic [2:0] MODE_IDLE     = 3'd1;
  localparam logic [2:0] MODE_DEBOUNCE = 3'd2;
  localparam logic [2:0] MODE_HOLD     = 3'd3;
  localparam logic [2:0] MODE_RELEASE  = 3'd4;
  localparam logic [2:0] MODE_ALIGN    = 3'd5;
  localparam logic [2:0] MODE_SCAN     = 3'd6;
  localparam logic [2:0] MODE_SEEK     = 3'd7;

  localparam logic [1:0] REG_DEBOUNCE    = 2'd0;
  localparam logic [1:0] REG_LONG_PRESS  = 2'd1;
  localparam logic [1:0] REG_SHORT_LIMIT = 2'd2;

  localparam logic [7:0] DEBOUNCE_RESET    = 8'd5;
  localparam logic [9:0] LONG_PRESS_RESET  = 10'd100;
  localparam logic [9:0] SHORT_LIMIT_RESET = 10'd30;

  localparam logic [7:0]  TICK_RUN_MAX = 8'd255;
  localparam logic [9:0]  PRESS_MAX    = 10'd1023;
  localparam logic [1:0]  TURN_MAX     = 2'd3;

  // Bit (old_pair | new_pair << 2) set means backward rotation.
  localparam logic [15:0] BACKWARD_KEYS = 16'h4182;

  typedef struct packed {
    logic [7:0] debounce_ticks;
    logic [9:0] long_press_ticks;
    logic [9:0] short_press_limit;
  } rpsc_cfg_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       button_released;
    logic [1:0] sensor_pair;
    logic [9:0] sample;
  } rpsc_item_t;

  typedef struct packed {
    logic        drive_a;
    logic        drive_b;
    logic [15:0] angle_now;
    logic [14:0] best_angle;
    logic [9:0]  best_level;
    logic [2:0]  mode_code;
  } rpsc_view_t;

endpackage

[rtl/rotary_peak_scan_controller.sv]
// ----------------------------------------------------------------------------
// rotary_peak_scan_controller
// Turntable motor controller driven by tick, index and encoder beats.
//
//   channel  handshake              payload
//   in       in_valid / in_ready    cmd, button_released, sensor_pair, sample
//   out      out_valid / out_ready  drive_a, drive_b, angle_now, best_angle,
//                                   best_level, mode_code
//   cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One beat is taken per cycle while the result is not stalled; its result
// passes from the input register through the combinational state update
// into the result register. Reset loads the register defaults and the
// startup state, with no clearing pass. A stalled result holds the input
// register, and input is refused only while both registers are full.
// ----------------------------------------------------------------------------
module rotary_peak_scan_controller
  import rpsc_pkg::*;
#(
  parameter int POSITION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         cmd,
  input  logic               button_released,
  input  logic [1:0]         sensor_pair,
  input  logic [9:0]         sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               drive_a,
  output logic               drive_b,
  output logic signed [15:0] angle_now,
  output logic [14:0]        best_angle,
  output logic [9:0]         best_level,
  output logic [2:0]         mode_code,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [9:0]         cfg_data
);

  rpsc_cfg_t  cfg;
  rpsc_item_t held;
  logic       held_valid;
  logic       step;
  rpsc_view_t view_next;
  rpsc_view_t result;

  assign cfg_ready = 1'b1;
  assign step      = held_valid && (!out_valid || out_ready);
  assign in_ready  = !held_valid || step;

  rpsc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rpsc_core #(
    .POSITION_BITS (POSITION_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .item      (held),
    .cfg       (cfg),
    .view_next (view_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        held_valid <= 1'b1;
      end else if (step) begin
        held_valid <= 1'b0;
      end
      if (step) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held.cmd             <= cmd;
      held.button_released <= button_released;
      held.sensor_pair     <= sensor_pair;
      held.sample          <= sample;
    end
    if (step) begin
      result <= view_next;
    end
  end

  assign drive_a    = result.drive_a;
  assign drive_b    = result.drive_b;
  assign angle_now  = result.angle_now;
  assign best_angle = result.best_angle;
  assign best_level = result.best_level;
  assign mode_code  = result.mode_code;

endmodule

[rtl/rpsc_cfg.sv]
// ----------------------------------------------------------------------------
// rpsc_cfg
// Configuration register file written through its own valid/ready channel.
// ----------------------------------------------------------------------------
module rpsc_cfg
  import rpsc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  input  logic [1:0] cfg_index,
  input  logic [9:0] cfg_data,
  output rpsc_cfg_t  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks    <= DEBOUNCE_RESET;
      cfg.long_press_ticks  <= LONG_PRESS_RESET;
      cfg.short_press_limit <= SHORT_LIMIT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DEBOUNCE:    cfg.debounce_ticks    <= cfg_data[7:0];
        REG_LONG_PRESS:  cfg.long_press_ticks  <= cfg_data;
        REG_SHORT_LIMIT: cfg.short_press_limit <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

[rtl/rpsc_core.sv]
// ----------------------------------------------------------------------------
// rpsc_core
// Controller state and the combinational update applied for each item.
// ----------------------------------------------------------------------------
module rpsc_core
  import rpsc_pkg::*;
#(
  parameter int POSITION_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  rpsc_item_t item,
  input  rpsc_cfg_t  cfg,
  output rpsc_view_t view_next
);

  localparam logic [POSITION_BITS-1:0] POS_MAXP = {1'b0, {(POSITION_BITS-1){1'b1}}};
  localparam logic [POSITION_BITS-1:0] POS_MASK = {POSITION_BITS{1'b1}};
  localparam logic [POSITION_BITS-1:0] POS_ONE  = {{(POSITION_BITS-1){1'b0}}, 1'b1};

  logic [2:0]               mode, mode_next;
  logic [7:0]               tick_run, tick_run_next;
  logic [9:0]               press_time, press_time_next;
  logic [POSITION_BITS-1:0] position, position_next;
  logic [1:0]               turn_count, turn_count_next;
  logic [POSITION_BITS-1:0] peak_pos, peak_pos_next;
  logic [9:0]               peak_val, peak_val_next;
  logic                     sampling_on, sampling_on_next;
  logic                     direction_pending, direction_pending_next;
  logic                     forward_line, forward_line_next;
  logic                     running, running_next;
  logic                     pair_latched;
  logic [1:0]               prior_pair, prior_pair_next;

  logic [3:0]               dir_key;
  logic [POSITION_BITS+15:0] pos_wide, peak_wide;

  always_comb begin
    mode_next              = mode;
    tick_run_next          = tick_run;
    press_time_next        = press_time;
    position_next          = position;
    turn_count_next        = turn_count;
    peak_pos_next          = peak_pos;
    peak_val_next          = peak_val;
    sampling_on_next       = sampling_on;
    direction_pending_next = direction_pending;
    forward_line_next      = forward_line;
    running_next           = running;
    prior_pair_next        = pair_latched ? prior_pair : item.sensor_pair;
    dir_key                = {item.sensor_pair, prior_pair_next};

    if (item.cmd == CMD_INDEX) begin
      position_next = '0;
      if (turn_count < TURN_MAX) begin
        turn_count_next = turn_count + 2'd1;
      end
    end else if (item.cmd == CMD_EDGE) begin
      if (direction_pending) begin
        direction_pending_next = 1'b0;
        if (BACKWARD_KEYS[dir_key]) begin
          forward_line_next = !forward_line;
          running_next      = 1'b1;
        end
      end else begin
        if (position == POS_MASK) begin
          position_next = '0;
        end else if (position < POS_MAXP) begin
          position_next = position + POS_ONE;
        end
        if (sampling_on && (item.sample > peak_val)) begin
          peak_val_next = item.sample;
          peak_pos_next = position_next;
        end
      end
    end else if (item.cmd == CMD_TICK) begin
      unique case (mode)
        MODE_IDLE: begin
          press_time_next = '0;
          if (!item.button_released) begin
            tick_run_next = '0;
            mode_next     = MODE_DEBOUNCE;
          end
        end
        MODE_DEBOUNCE: begin
          if (tick_run < TICK_RUN_MAX) begin
            tick_run_next = tick_run + 8'd1;
          end
          if (tick_run_next >= cfg.debounce_ticks) begin
            if (item.button_released) begin
              mode_next = MODE_IDLE;
            end else begin
              press_time_next = {2'b00, cfg.debounce_ticks};
              mode_next       = MODE_HOLD;
            end
          end
        end
        MODE_HOLD: begin
          if (item.button_released) begin
            tick_run_next = '0;
            mode_next     = MODE_RELEASE;
          end else if (press_time < PRESS_MAX) begin
            press_time_next = press_time + 10'd1;
          end
        end
        MODE_RELEASE: begin
          if (tick_run < TICK_RUN_MAX) begin
            tick_run_next = tick_run + 8'd1;
          end
          if (tick_run_next >= cfg.debounce_ticks) begin
            if (press_time > cfg.long_press_ticks) begin
              turn_count_next = '0;
              running_next    = 1'b1;
              if (position_next != '0) begin
                mode_next = MODE_ALIGN;
              end else begin
                sampling_on_next = 1'b1;
                peak_pos_next    = '0;
                peak_val_next    = '0;
                mode_next        = MODE_SCAN;
              end
            end else begin
              if ((press_time < cfg.short_press_limit) && (press_time != '0)) begin
                running_next = !running;
              end
              mode_next = MODE_IDLE;
            end
          end
        end
        default: begin
        end
      endcase
    end

    if ((mode_next == MODE_STARTUP) && (turn_count_next != '0)) begin
      running_next    = 1'b0;
      turn_count_next = '0;
      position_next   = '0;
      peak_pos_next   = '0;
      peak_val_next   = '0;
      mode_next       = MODE_IDLE;
    end else if ((mode_next == MODE_ALIGN) && (turn_count_next != '0)) begin
      turn_count_next  = '0;
      sampling_on_next = 1'b1;
      peak_pos_next    = '0;
      peak_val_next    = '0;
      running_next     = 1'b1;
      mode_next        = MODE_SCAN;
    end else if ((mode_next == MODE_SCAN) && (turn_count_next != '0)) begin
      sampling_on_next = 1'b0;
      mode_next        = MODE_SEEK;
    end
    if ((mode_next == MODE_SEEK) &&
        ((position_next == peak_pos_next) || turn_count_next[1])) begin
      running_next = 1'b0;
      mode_next    = MODE_IDLE;
    end

    pos_wide  = {16'd0, position_next};
    peak_wide = {16'd0, peak_pos_next};

    view_next.drive_a    = running_next ? forward_line_next : 1'b1;
    view_next.drive_b    = running_next ? !forward_line_next : 1'b1;
    view_next.angle_now  = pos_wide[15:0];
    view_next.best_angle = peak_wide[14:0];
    view_next.best_level = peak_val_next;
    view_next.mode_code  = mode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode              <= MODE_STARTUP;
      tick_run          <= '0;
      press_time        <= '0;
      position          <= POS_MASK;
      turn_count        <= '0;
      peak_pos          <= '0;
      peak_val          <= '0;
      sampling_on       <= 1'b0;
      direction_pending <= 1'b1;
      forward_line      <= 1'b1;
      running           <= 1'b1;
      pair_latched      <= 1'b0;
      prior_pair        <= '0;
    end else if (step) begin
      mode              <= mode_next;
      tick_run          <= tick_run_next;
      press_time        <= press_time_next;
      position          <= position_next;
      turn_count        <= turn_count_next;
      peak_pos          <= peak_pos_next;
      peak_val          <= peak_val_next;
      sampling_on       <= sampling_on_next;
      direction_pending <= direction_pending_next;
      forward_line      <= forward_line_next;
      running           <= running_next;
      pair_latched      <= 1'b1;
      prior_pair        <= prior_pair_next;
    end
  end

endmodule
